/* src/ttocs_pkg.sv */
// ----------------------------------------------------------------------------
// ttocs_pkg: shared definitions for the timed two-output cycle sequencer
// Register indexes, reset values, the phase encoding and the structs that
// travel between the sequencer's modules.
// ----------------------------------------------------------------------------
package ttocs_pkg;

  localparam int WAIT_W          = 20;
  localparam int CFG_DATA_W      = 20;
  localparam int REG_IDX_W       = 3;
  localparam int TIMER_BITS_DEF  = 20;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [WAIT_W-1:0] WAIT_FIRST_RST  = 20'd2000;
  localparam logic [WAIT_W-1:0] WAIT_SECOND_RST = 20'd12000;
  localparam logic [WAIT_W-1:0] WAIT_THIRD_RST  = 20'd300;
  localparam logic [WAIT_W-1:0] WAIT_FOURTH_RST = 20'd20200;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_MODE        = 3'd0;
  localparam reg_idx_t REG_WAIT_FIRST  = 3'd1;
  localparam reg_idx_t REG_WAIT_SECOND = 3'd2;
  localparam reg_idx_t REG_WAIT_THIRD  = 3'd3;
  localparam reg_idx_t REG_WAIT_FOURTH = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ONE   = 3'd1,
    PH_TWO   = 3'd2,
    PH_THREE = 3'd3,
    PH_FOUR  = 3'd4
  } phase_t;

  typedef struct packed {
    logic              mode;
    logic [WAIT_W-1:0] wait_first;
    logic [WAIT_W-1:0] wait_second;
    logic [WAIT_W-1:0] wait_third;
    logic [WAIT_W-1:0] wait_fourth;
  } cfg_t;

  // Control flags of the sequencer: output levels, busy flag and phase.
  typedef struct packed {
    logic   acc;
    logic   rev;
    logic   busy;
    phase_t phase;
  } ctrl_t;

endpackage

/* src/ttocs_cfg.sv */
// ----------------------------------------------------------------------------
// ttocs_cfg: configuration registers
// Holds the mode bit and the four phase waits, written through a plain port.
// ----------------------------------------------------------------------------
module ttocs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  ttocs_pkg::reg_idx_t                 cfg_index,
  input  logic [ttocs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ttocs_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= 1'b0;
      cfg.wait_first  <= ttocs_pkg::WAIT_FIRST_RST;
      cfg.wait_second <= ttocs_pkg::WAIT_SECOND_RST;
      cfg.wait_third  <= ttocs_pkg::WAIT_THIRD_RST;
      cfg.wait_fourth <= ttocs_pkg::WAIT_FOURTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ttocs_pkg::REG_MODE:        cfg.mode        <= cfg_data[0];
        ttocs_pkg::REG_WAIT_FIRST:  cfg.wait_first  <= cfg_data[ttocs_pkg::WAIT_W-1:0];
        ttocs_pkg::REG_WAIT_SECOND: cfg.wait_second <= cfg_data[ttocs_pkg::WAIT_W-1:0];
        ttocs_pkg::REG_WAIT_THIRD:  cfg.wait_third  <= cfg_data[ttocs_pkg::WAIT_W-1:0];
        ttocs_pkg::REG_WAIT_FOURTH: cfg.wait_fourth <= cfg_data[ttocs_pkg::WAIT_W-1:0];
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

endmodule

/* src/ttocs_step.sv */
// ----------------------------------------------------------------------------
// ttocs_step: next-state logic for one tick
// Saturating timer increment, wait compare and the phase transition table.
// ----------------------------------------------------------------------------
module ttocs_step #(
  parameter int TIMER_BITS = ttocs_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = ttocs_pkg::COUNT_BITS_DEF
) (
  input  ttocs_pkg::cfg_t         cfg,
  input  logic                    switch_low,
  input  ttocs_pkg::ctrl_t        ctrl,
  input  logic [TIMER_BITS-1:0]   elapsed,
  input  logic [COUNT_BITS-1:0]   cycles,
  output ttocs_pkg::ctrl_t        ctrl_next,
  output logic [TIMER_BITS-1:0]   elapsed_next,
  output logic [COUNT_BITS-1:0]   cycles_next
);

  localparam int CMP_W = (TIMER_BITS > ttocs_pkg::WAIT_W) ? TIMER_BITS : ttocs_pkg::WAIT_W;

  logic [TIMER_BITS-1:0]        elapsed_inc;
  logic [ttocs_pkg::WAIT_W-1:0] wait_sel;
  logic                         due;
  logic                         permit;

  always_comb begin
    elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;

    // Idle selects a zero wait, so it is always due; it moves once the tick is permitted (switch low or busy).
    case (ctrl.phase)
      ttocs_pkg::PH_ONE:   wait_sel = cfg.wait_first;
      ttocs_pkg::PH_TWO:   wait_sel = cfg.wait_second;
      ttocs_pkg::PH_THREE: wait_sel = cfg.wait_third;
      ttocs_pkg::PH_FOUR:  wait_sel = cfg.wait_fourth;
      default:             wait_sel = '0;
    endcase

    due    = CMP_W'(elapsed_inc) >= CMP_W'(wait_sel);
    permit = switch_low || ctrl.busy;

    ctrl_next    = ctrl;
    cycles_next  = cycles;
    elapsed_next = (permit && due) ? '0 : elapsed_inc;

    if (permit && due) begin
      case (ctrl.phase)
        ttocs_pkg::PH_ONE: begin
          if (cfg.mode) begin
            ctrl_next.acc = 1'b0;
          end else begin
            ctrl_next.rev = 1'b1;
          end
          ctrl_next.busy  = 1'b1;
          cycles_next     = cycles + 1'b1;
          ctrl_next.phase = ttocs_pkg::PH_TWO;
        end
        ttocs_pkg::PH_TWO: begin
          if (cfg.mode) begin
            ctrl_next.acc = 1'b1;
          end else begin
            ctrl_next.rev = 1'b0;
          end
          ctrl_next.phase = ttocs_pkg::PH_THREE;
        end
        ttocs_pkg::PH_THREE: begin
          ctrl_next.acc = 1'b0;
          if (!cfg.mode) begin
            ctrl_next.busy = 1'b0;
          end
          ctrl_next.phase = ttocs_pkg::PH_FOUR;
        end
        ttocs_pkg::PH_FOUR: begin
          ctrl_next.acc   = 1'b1;
          ctrl_next.phase = ttocs_pkg::PH_ONE;
        end
        default: begin
          ctrl_next.acc   = 1'b1;
          ctrl_next.phase = ttocs_pkg::PH_ONE;
        end
      endcase
    end
  end

endmodule

/* src/ttocs_out_reg.sv */
// ----------------------------------------------------------------------------
// ttocs_out_reg: result register
// Holds one result request until the consumer takes it.
// ----------------------------------------------------------------------------
module ttocs_out_reg #(
  parameter int COUNT_BITS = ttocs_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ttocs_pkg::ctrl_t      ctrl_in,
  input  logic [COUNT_BITS-1:0] cycles_in,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttocs_pkg::ctrl_t      ctrl_out,
  output logic [COUNT_BITS-1:0] cycles_out
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_out   <= ctrl_in;
      cycles_out <= cycles_in;
    end
  end

endmodule

/* src/timed_two_output_cycle_sequencer_core.sv */
// ----------------------------------------------------------------------------
// timed_two_output_cycle_sequencer_core: timed two-output cycle sequencer
// Each request is one millisecond tick carrying the start switch level; each
// tick yields one result with the output levels, cycle count, phase and busy.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its tick request is accepted.
// Throughput: one tick per cycle while results are read; the state update and
// the result register load happen at the same edge, and the result register
// frees as it is read, so a new tick is taken in the same cycle a result leaves.
// Reset (rst, synchronous, active high) sets the phase to idle, clears the
// timer, busy flag, both outputs and the cycle count, and restores the waits.
// ----------------------------------------------------------------------------
module timed_two_output_cycle_sequencer_core #(
  parameter int TIMER_BITS = ttocs_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = ttocs_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_write,
  input  ttocs_pkg::reg_idx_t              cfg_index,
  input  logic [ttocs_pkg::CFG_DATA_W-1:0] cfg_data,
  // Tick requests.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             switch_low,
  // Results.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             acc_drive,
  output logic                             rev_drive,
  output logic [COUNT_BITS-1:0]            cycle_count,
  output logic [2:0]                       phase_now,
  output logic                             busy_res
);

  ttocs_pkg::cfg_t        cfg;
  ttocs_pkg::ctrl_t       ctrl;
  ttocs_pkg::ctrl_t       ctrl_next;
  ttocs_pkg::ctrl_t       ctrl_res;
  logic [TIMER_BITS-1:0]  elapsed;
  logic [TIMER_BITS-1:0]  elapsed_next;
  logic [COUNT_BITS-1:0]  cycles;
  logic [COUNT_BITS-1:0]  cycles_next;
  logic                   accept;

  ttocs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A tick is taken whenever the result register is empty or being emptied.
  assign accept = in_valid && in_ready;

  ttocs_step #(
    .TIMER_BITS (TIMER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg          (cfg),
    .switch_low   (switch_low),
    .ctrl         (ctrl),
    .elapsed      (elapsed),
    .cycles       (cycles),
    .ctrl_next    (ctrl_next),
    .elapsed_next (elapsed_next),
    .cycles_next  (cycles_next)
  );

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.acc   <= 1'b0;
      ctrl.rev   <= 1'b0;
      ctrl.busy  <= 1'b0;
      ctrl.phase <= ttocs_pkg::PH_IDLE;
      elapsed    <= '0;
      cycles     <= '0;
    end else if (accept) begin
      ctrl    <= ctrl_next;
      elapsed <= elapsed_next;
      cycles  <= cycles_next;
    end
  end

  // The result carries the state as it stands after the tick.
  ttocs_out_reg #(
    .COUNT_BITS (COUNT_BITS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .ctrl_in    (ctrl_next),
    .cycles_in  (cycles_next),
    .slot_free  (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctrl_out   (ctrl_res),
    .cycles_out (cycle_count)
  );

  assign acc_drive = ctrl_res.acc;
  assign rev_drive = ctrl_res.rev;
  assign busy_res  = ctrl_res.busy;
  assign phase_now = ctrl_res.phase;

endmodule
